@@ src/pus_pkg.sv @@
// Shared types and constants for the particle update step block.
// No dependencies; used by the top level and by the divider pipeline.
`default_nettype none
package pus_pkg;

    localparam int QBITS = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SIZE_MIN  = 3'd0,
        CFG_SIZE_MAX  = 3'd1,
        CFG_SIZE_GAIN = 3'd2,
        CFG_START_RGBA = 3'd3,
        CFG_END_RGBA  = 3'd4
    } cfg_index_t;

    // Motion results that travel alongside the lifetime division.
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] angle;
        logic [31:0] life_left;
        logic        alive;
        logic        full_ratio;
    } motion_t;

endpackage
`default_nettype wire

@@ src/pus_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a carried payload.
// Depends on pus_pkg for the fraction width.
`default_nettype none
module pus_div
    import pus_pkg::*;
#(
    parameter int PAYLOAD_W = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [30:0]          dividend,
    input  wire logic [30:0]          divisor,
    input  wire logic [PAYLOAD_W-1:0] in_payload,
    output logic                      out_valid,
    output logic [QBITS-1:0]          quotient,
    output logic [PAYLOAD_W-1:0]      out_payload
);

    // When the dividend is below the divisor, the remainder always fits in 31 bits.
    logic                 valid_reg   [QBITS+1];
    logic [30:0]          rem_reg     [QBITS+1];
    logic [30:0]          dvs_reg     [QBITS+1];
    logic [QBITS-1:0]     quo_reg     [QBITS+1];
    logic [PAYLOAD_W-1:0] payload_reg [QBITS+1];

    always_comb
    begin
        valid_reg[0]   = in_valid;
        rem_reg[0]     = dividend;
        dvs_reg[0]     = divisor;
        quo_reg[0]     = '0;
        payload_reg[0] = in_payload;
    end

    for (genvar s = 0; s < QBITS; s++) begin : g_stage
        logic [31:0] shifted;
        logic        take;
        logic [31:0] diff;

        always_comb
        begin
            shifted = {rem_reg[s], 1'b0};
            diff    = shifted - {1'b0, dvs_reg[s]};
            take    = shifted >= {1'b0, dvs_reg[s]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]     <= take ? diff[30:0] : shifted[30:0];
            dvs_reg[s+1]     <= dvs_reg[s];
            quo_reg[s+1]     <= {quo_reg[s][QBITS-2:0], take};
            payload_reg[s+1] <= payload_reg[s];
        end
    end

    assign out_valid   = valid_reg[QBITS];
    assign quotient    = quo_reg[QBITS];
    assign out_payload = payload_reg[QBITS];

endmodule
`default_nettype wire

@@ src/particle_update_step.sv @@
// Particle update step: one semi-implicit Euler step per particle, Q16.16 fixed point.
// Depends on pus_pkg and on the pus_div divider pipeline.
//
// A transaction is accepted at every rising edge where start is high; busy is
// always low because the block is fully pipelined and takes one particle per
// clock. The result appears on the output ports for exactly one cycle with
// done high, and cannot be held off by the receiver.
// The pipeline has four motion stages (velocity product, velocity add,
// position product, position add), sixteen stages of the lifetime-ratio
// divider (one quotient bit each) and three stages for size and color.
// Configuration registers may only be written while no transaction is in flight.
`default_nettype none
module particle_update_step
    import pus_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    output logic                        done,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic [15:0]            delta_time,
    input  wire logic signed [31:0]     pos_x,
    input  wire logic signed [31:0]     pos_y,
    input  wire logic signed [31:0]     vel_x,
    input  wire logic signed [31:0]     vel_y,
    input  wire logic signed [31:0]     acc_x,
    input  wire logic signed [31:0]     acc_y,
    input  wire logic signed [31:0]     angle,
    input  wire logic signed [31:0]     spin_rate,
    input  wire logic signed [31:0]     life_left,
    input  wire logic [30:0]            life_max,
    output logic signed [31:0]          new_pos_x,
    output logic signed [31:0]          new_pos_y,
    output logic signed [31:0]          new_vel_x,
    output logic signed [31:0]          new_vel_y,
    output logic signed [31:0]          new_angle,
    output logic signed [31:0]          new_life_left,
    output logic                        alive,
    output logic signed [31:0]          new_size,
    output logic [7:0]                  color_r,
    output logic [7:0]                  color_g,
    output logic [7:0]                  color_b,
    output logic [7:0]                  color_a
);

    localparam int LATENCY = 23;

    // Configuration registers.
    logic signed [31:0] size_min_reg;
    logic signed [31:0] size_max_reg;
    logic signed [31:0] size_gain_reg;
    logic [31:0]        start_rgba_reg;
    logic [31:0]        end_rgba_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_min_reg   <= 32'sd0;
            size_max_reg   <= 32'sd65536;
            size_gain_reg  <= 32'sd65536;
            start_rgba_reg <= 32'hFFFF_FFFF;
            end_rgba_reg   <= 32'h0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_MIN:   size_min_reg   <= cfg_data;
                CFG_SIZE_MAX:   size_max_reg   <= cfg_data;
                CFG_SIZE_GAIN:  size_gain_reg  <= cfg_data;
                CFG_START_RGBA: start_rgba_reg <= cfg_data;
                CFG_END_RGBA:   end_rgba_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: acceleration and spin products, life after the step.
    logic               v1_reg;
    logic signed [48:0] pax1_reg, pay1_reg, pspin1_reg;
    logic signed [32:0] nlife1_reg;
    logic [15:0]        dt1_reg;
    logic signed [31:0] px1_reg, py1_reg, vx1_reg, vy1_reg, ang1_reg;
    logic [30:0]        lmax1_reg;

    // Stage 2: new velocity and angle.
    logic               v2_reg;
    logic signed [31:0] vx2_reg, vy2_reg, ang2_reg, px2_reg, py2_reg;
    logic signed [32:0] nlife2_reg;
    logic [15:0]        dt2_reg;
    logic [30:0]        lmax2_reg;

    // Stage 3: velocity times time step.
    logic               v3_reg;
    logic signed [48:0] pvx3_reg, pvy3_reg;
    logic signed [31:0] vx3_reg, vy3_reg, ang3_reg, px3_reg, py3_reg;
    logic signed [32:0] nlife3_reg;
    logic [30:0]        lmax3_reg;

    // Stage 4: positions and lifetime classification, feeding the divider.
    logic        v4_reg;
    motion_t     mot4_reg;
    logic [30:0] rem4_reg;
    logic [30:0] lmax4_reg;
    motion_t     mot4_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        mot4_next.pos_x = px3_reg + 32'(pvx3_reg >>> QBITS);
        mot4_next.pos_y = py3_reg + 32'(pvy3_reg >>> QBITS);
        mot4_next.vel_x = vx3_reg;
        mot4_next.vel_y = vy3_reg;
        mot4_next.angle = ang3_reg;
        // Life can only fall below the 32-bit range, never above it.
        if (nlife3_reg[32] && !nlife3_reg[31])
            mot4_next.life_left = 32'h8000_0000;
        else
            mot4_next.life_left = nlife3_reg[31:0];
        mot4_next.alive = (nlife3_reg > 33'sd0);
        mot4_next.full_ratio = (lmax3_reg == 31'd0) ||
                               (nlife3_reg >= $signed({2'b00, lmax3_reg}));
    end

    always_ff @(posedge clk)
    begin
        pax1_reg   <= acc_x * $signed({1'b0, delta_time});
        pay1_reg   <= acc_y * $signed({1'b0, delta_time});
        pspin1_reg <= spin_rate * $signed({1'b0, delta_time});
        nlife1_reg <= $signed({life_left[31], life_left}) - $signed({17'b0, delta_time});
        dt1_reg    <= delta_time;
        px1_reg    <= pos_x;
        py1_reg    <= pos_y;
        vx1_reg    <= vel_x;
        vy1_reg    <= vel_y;
        ang1_reg   <= angle;
        lmax1_reg  <= life_max;

        vx2_reg    <= vx1_reg + 32'(pax1_reg >>> QBITS);
        vy2_reg    <= vy1_reg + 32'(pay1_reg >>> QBITS);
        ang2_reg   <= ang1_reg + 32'(pspin1_reg >>> QBITS);
        px2_reg    <= px1_reg;
        py2_reg    <= py1_reg;
        nlife2_reg <= nlife1_reg;
        dt2_reg    <= dt1_reg;
        lmax2_reg  <= lmax1_reg;

        pvx3_reg   <= vx2_reg * $signed({1'b0, dt2_reg});
        pvy3_reg   <= vy2_reg * $signed({1'b0, dt2_reg});
        vx3_reg    <= vx2_reg;
        vy3_reg    <= vy2_reg;
        ang3_reg   <= ang2_reg;
        px3_reg    <= px2_reg;
        py3_reg    <= py2_reg;
        nlife3_reg <= nlife2_reg;
        lmax3_reg  <= lmax2_reg;

        mot4_reg  <= mot4_next;
        rem4_reg  <= nlife3_reg[30:0];
        lmax4_reg <= lmax3_reg;
    end

    // Lifetime ratio r = life * 2^16 / life_max; only meaningful for a live
    // particle whose life is below the full lifetime.
    logic             dv_valid;
    logic [QBITS-1:0] dv_quo;
    motion_t          dv_mot;

    pus_div #(
        .PAYLOAD_W ($bits(motion_t))
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v4_reg),
        .dividend    (rem4_reg),
        .divisor     (lmax4_reg),
        .in_payload  (mot4_reg),
        .out_valid   (dv_valid),
        .quotient    (dv_quo),
        .out_payload (dv_mot)
    );

    // Stage M1: u = 1 - r, first size product and color products.
    logic signed [17:0] u_s;
    logic signed [32:0] size_diff;
    logic               m1v_reg;
    motion_t            m1mot_reg;
    logic signed [33:0] t1_reg;
    logic signed [9:0]  c1_reg [4];

    always_comb
    begin
        u_s       = dv_mot.full_ratio ? 18'sd0 : $signed(18'd65536 - {2'b00, dv_quo});
        size_diff = $signed({size_max_reg[31], size_max_reg}) -
                    $signed({size_min_reg[31], size_min_reg});
    end

    for (genvar c = 0; c < 4; c++) begin : g_color
        logic signed [8:0]  a_s, b_s;
        logic signed [26:0] prod;

        always_comb
        begin
            a_s  = $signed({1'b0, start_rgba_reg[8*c +: 8]});
            b_s  = $signed({1'b0, end_rgba_reg[8*c +: 8]});
            prod = (b_s - a_s) * u_s;
        end

        always_ff @(posedge clk)
        begin
            c1_reg[c] <= $signed({a_s[8], a_s}) + 10'(prod >>> QBITS);
        end
    end

    always_ff @(posedge clk)
    begin
        m1mot_reg <= dv_mot;
        t1_reg    <= 34'((51'(size_diff) * 51'(u_s)) >>> QBITS);
    end

    // Stage M2: gain product and color clamp.
    logic               m2v_reg;
    motion_t            m2mot_reg;
    logic signed [49:0] t2_reg;
    logic [7:0]         c2_reg [4];

    always_ff @(posedge clk)
    begin
        m2mot_reg <= m1mot_reg;
        t2_reg    <= 50'((66'(t1_reg) * 66'(size_gain_reg)) >>> QBITS);
        for (int c = 0; c < 4; c++)
        begin
            if (c1_reg[c] < 10'sd0)
                c2_reg[c] <= 8'd0;
            else if (c1_reg[c] > 10'sd255)
                c2_reg[c] <= 8'd255;
            else
                c2_reg[c] <= c1_reg[c][7:0];
        end
    end

    // Output stage: size saturation and the dead-particle blanking.
    logic signed [50:0] size_sum;
    logic signed [31:0] size_next;

    always_comb
    begin
        size_sum = 51'(size_min_reg) + 51'(t2_reg);
        if (size_sum > 51'sd2147483647)
            size_next = 32'sh7FFF_FFFF;
        else if (size_sum < -51'sd2147483648)
            size_next = 32'sh8000_0000;
        else
            size_next = size_sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1v_reg <= 1'b0;
            m2v_reg <= 1'b0;
            done    <= 1'b0;
        end
        else
        begin
            m1v_reg <= dv_valid;
            m2v_reg <= m1v_reg;
            done    <= m2v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        new_pos_x     <= m2mot_reg.pos_x;
        new_pos_y     <= m2mot_reg.pos_y;
        new_vel_x     <= m2mot_reg.vel_x;
        new_vel_y     <= m2mot_reg.vel_y;
        new_angle     <= m2mot_reg.angle;
        new_life_left <= m2mot_reg.life_left;
        alive         <= m2mot_reg.alive;
        new_size      <= m2mot_reg.alive ? size_next : 32'sd0;
        color_a       <= m2mot_reg.alive ? c2_reg[0] : 8'd0;
        color_b       <= m2mot_reg.alive ? c2_reg[1] : 8'd0;
        color_g       <= m2mot_reg.alive ? c2_reg[2] : 8'd0;
        color_r       <= m2mot_reg.alive ? c2_reg[3] : 8'd0;
    end

    // Every accepted transaction is followed by a result with done high.
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    // A dead particle reports zero size and a black, transparent color.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !alive) |-> (new_size == 32'sd0 && color_r == 8'd0 &&
                              color_g == 8'd0 && color_b == 8'd0 && color_a == 8'd0))
        else $error("dead particle with nonzero size or color");

    // A live particle always has positive remaining life.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && alive) |-> (new_life_left > 32'sd0))
        else $error("alive flag disagrees with remaining life");

endmodule
`default_nettype wire

@@ sim/particle_update_step_tb.sv @@
// Self-checking testbench for particle_update_step: directed table, size and color extremes, then random particles.
// Depends on pus_pkg and the particle_update_step RTL; predicts results in fixed point, apart from typed-in rows.
`timescale 1ns / 1ps
module particle_update_step_tb;
    import pus_pkg::*;

    // Pipeline depth of the block, as its LATENCY parameter has it.
    localparam int LATENCY = 23;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1900;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [31:0] cfg_data;
    logic [15:0] delta_time;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
    logic signed [31:0] angle, spin_rate, life_left;
    logic [30:0] life_max;
    logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
    logic signed [31:0] new_angle, new_life_left, new_size;
    logic alive;
    logic [7:0] color_r, color_g, color_b, color_a;

    // One particle record as presented on the input ports.
    typedef struct {
        logic [15:0] dt;
        logic [31:0] px, py, vx, vy, ax, ay, ang, spin, life;
        logic [30:0] lmax;
    } particle_t;

    // One updated particle as seen on the output ports.
    typedef struct {
        logic [31:0] px, py, vx, vy, ang, life;
        logic        live;
        logic [31:0] size;
        logic [7:0]  r, g, b, a;
    } update_t;

    // A directed row: the record, and optionally a typed-in expectation.
    typedef struct {
        particle_t p;
        logic      has_fixed;
        update_t   fixed;
    } row_t;

    update_t pending_updates[$];
    int      error_count;
    int      idle_cycles;

    // Shadow copy of the configuration registers.
    logic [31:0] sh_size_min, sh_size_max, sh_size_gain, sh_start_rgba, sh_end_rgba;

    particle_update_step dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .delta_time(delta_time), .pos_x(pos_x), .pos_y(pos_y),
        .vel_x(vel_x), .vel_y(vel_y), .acc_x(acc_x), .acc_y(acc_y),
        .angle(angle), .spin_rate(spin_rate), .life_left(life_left),
        .life_max(life_max), .new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_angle(new_angle),
        .new_life_left(new_life_left), .alive(alive), .new_size(new_size),
        .color_r(color_r), .color_g(color_g), .color_b(color_b), .color_a(color_a)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Floor of a signed 128-bit value divided by 2^16. The arithmetic shift of
    // a signed vector already rounds toward minus infinity.
    function automatic logic signed [127:0] floor16(input logic signed [127:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 128'sd2147483647;
        if (v < -128'sd2147483648)
            return -128'sd2147483648;
        return v;
    endfunction

    // Blend one color byte from start toward end by the elapsed fraction u.
    function automatic logic [7:0] blend_byte(input logic [7:0] s, input logic [7:0] e,
                                              input logic signed [127:0] u);
        logic signed [127:0] c;
        c = $signed({120'd0, s}) + floor16(($signed({120'd0, e}) - $signed({120'd0, s})) * u);
        if (c < 0)
            c = 0;
        if (c > 255)
            c = 255;
        return c[7:0];
    endfunction

    // Semi-implicit Euler step with lifetime-driven size and color.
    function automatic update_t predict_update(input particle_t p);
        update_t o;
        logic signed [127:0] dt, vx, vy, nlife, ratio, u, diff, t, lmax;
        dt = $signed({112'd0, p.dt});
        vx = $signed(p.vx) + floor16($signed(p.ax) * dt);
        vy = $signed(p.vy) + floor16($signed(p.ay) * dt);
        // Velocity wraps before it drives the position.
        vx = $signed(vx[31:0]);
        vy = $signed(vy[31:0]);
        o.vx = vx[31:0];
        o.vy = vy[31:0];
        t = $signed(p.px) + floor16(vx * dt);
        o.px = t[31:0];
        t = $signed(p.py) + floor16(vy * dt);
        o.py = t[31:0];
        t = $signed(p.ang) + floor16($signed(p.spin) * dt);
        o.ang = t[31:0];
        nlife = $signed(p.life) - dt;
        t = clamp32(nlife);
        o.life = t[31:0];
        o.live = nlife > 0;
        o.size = '0;
        o.r = '0;
        o.g = '0;
        o.b = '0;
        o.a = '0;
        if (o.live)
        begin
            lmax = $signed({97'd0, p.lmax});
            if (lmax == 0 || nlife >= lmax)
                ratio = 65536;
            else
                ratio = (nlife <<< 16) / lmax;
            u = 65536 - ratio;
            diff = $signed(sh_size_max) - $signed(sh_size_min);
            t = floor16(u * diff);
            t = floor16(t * $signed(sh_size_gain));
            t = clamp32($signed(sh_size_min) + t);
            o.size = t[31:0];
            o.r = blend_byte(sh_start_rgba[31:24], sh_end_rgba[31:24], u);
            o.g = blend_byte(sh_start_rgba[23:16], sh_end_rgba[23:16], u);
            o.b = blend_byte(sh_start_rgba[15:8], sh_end_rgba[15:8], u);
            o.a = blend_byte(sh_start_rgba[7:0], sh_end_rgba[7:0], u);
        end
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $time);
        error_count++;
    endtask

    // Result checker: the receiver cannot stall, so every done cycle is taken.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            update_t w;
            if (pending_updates.size() == 0)
            begin
                $display("MISMATCH: result with nothing expected at %0t", $time);
                error_count++;
            end
            else
            begin
                w = pending_updates.pop_front();
                if (new_pos_x !== w.px) report_mismatch("new_pos_x", new_pos_x, w.px);
                if (new_pos_y !== w.py) report_mismatch("new_pos_y", new_pos_y, w.py);
                if (new_vel_x !== w.vx) report_mismatch("new_vel_x", new_vel_x, w.vx);
                if (new_vel_y !== w.vy) report_mismatch("new_vel_y", new_vel_y, w.vy);
                if (new_angle !== w.ang) report_mismatch("new_angle", new_angle, w.ang);
                if (new_life_left !== w.life)
                    report_mismatch("new_life_left", new_life_left, w.life);
                if (alive !== w.live) report_mismatch("alive", alive, w.live);
                if (new_size !== w.size) report_mismatch("new_size", new_size, w.size);
                if (color_r !== w.r) report_mismatch("color_r", color_r, w.r);
                if (color_g !== w.g) report_mismatch("color_g", color_g, w.g);
                if (color_b !== w.b) report_mismatch("color_b", color_b, w.b);
                if (color_a !== w.a) report_mismatch("color_a", color_a, w.a);
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Register writes happen only while nothing is in flight.
    task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            CFG_SIZE_MIN:   sh_size_min = value;
            CFG_SIZE_MAX:   sh_size_max = value;
            CFG_SIZE_GAIN:  sh_size_gain = value;
            CFG_START_RGBA: sh_start_rgba = value;
            default:        sh_end_rgba = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [31:0] smin, input logic [31:0] smax,
                             input logic [31:0] gain, input logic [31:0] srgba,
                             input logic [31:0] ergba);
        write_register(CFG_SIZE_MIN, smin);
        write_register(CFG_SIZE_MAX, smax);
        write_register(CFG_SIZE_GAIN, gain);
        write_register(CFG_START_RGBA, srgba);
        write_register(CFG_END_RGBA, ergba);
    endtask

    // Waits until every expected result is back, then lets the pipeline drain.
    task automatic drain_pipeline;
        while (pending_updates.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Presents one particle at a falling edge; start stays high into the next
    // particle unless the caller idles, so it is never dropped and raised at once.
    // Each idle cycle is drawn on its own, so each cycle is idle with a chance of 29 in a hundred.
    task automatic send_particle(input particle_t p, input logic idle_ok);
        while (idle_ok && $urandom_range(99) < 29)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        delta_time = p.dt;
        pos_x = p.px;
        pos_y = p.py;
        vel_x = p.vx;
        vel_y = p.vy;
        acc_x = p.ax;
        acc_y = p.ay;
        angle = p.ang;
        spin_rate = p.spin;
        life_left = p.life;
        life_max = p.lmax;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_updates.push_back(predict_update(p));
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_word;
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return $urandom_range(8) - 4;
            3: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
            default: return $urandom;
        endcase
    endfunction

    // Mostly live particles with sensible lifetimes; a share of dying ones and noise.
    function automatic particle_t random_particle;
        particle_t p;
        p.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
        p.px = random_word();
        p.py = random_word();
        p.vx = random_word();
        p.vy = random_word();
        p.ax = random_word();
        p.ay = random_word();
        p.ang = random_word();
        p.spin = random_word();
        case ($urandom_range(9))
            0: p.lmax = 31'd0;
            1: p.lmax = 31'($urandom);
            2: p.lmax = 31'h7FFF_FFFF;
            default: p.lmax = 31'($urandom_range(1, 10 * 65536));
        endcase
        case ($urandom_range(9))
            0: p.life = random_word();
            1: p.life = p.dt + $urandom_range(2) - 1;
            2: p.life = {1'b0, p.lmax} + $urandom_range(4);
            default: p.life = $urandom_range(0, p.lmax) + p.dt;
        endcase
        return p;
    endfunction

    function automatic particle_t make_particle(input logic [15:0] dt,
                                                input logic [31:0] v, input logic [31:0] a,
                                                input logic [31:0] life,
                                                input logic [30:0] lmax);
        particle_t p;
        p.dt = dt;
        p.px = v;
        p.py = ~v;
        p.vx = v;
        p.vy = ~v;
        p.ax = a;
        p.ay = ~a;
        p.ang = v;
        p.spin = a;
        p.life = life;
        p.lmax = lmax;
        return p;
    endfunction

    initial
    begin
        row_t directed[$];
        row_t rw;
        int cfg_choice;

        error_count = 0;
        idle_cycles = 0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SIZE_MIN;
        cfg_data = '0;
        delta_time = '0;
        {pos_x, pos_y, vel_x, vel_y, acc_x, acc_y} = '0;
        {angle, spin_rate, life_left} = '0;
        life_max = '0;
        sh_size_min = 32'h0;
        sh_size_max = 32'h0001_0000;
        sh_size_gain = 32'h0001_0000;
        sh_start_rgba = 32'hFFFF_FFFF;
        sh_end_rgba = 32'h0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed table. Rows with a typed-in answer use the reset registers:
        // an all-zero step of a dead particle, and a fresh particle at full life.
        rw.has_fixed = 1'b1;
        rw.p = make_particle(16'd0, 32'd0, 32'd0, 32'd0, 31'd0);
        rw.fixed = '{px: 0, py: 32'hFFFF_FFFF, vx: 0, vy: 32'hFFFF_FFFF, ang: 0, life: 0,
                     live: 0, size: 0, r: 0, g: 0, b: 0, a: 0};
        directed.push_back(rw);
        rw.p = make_particle(16'd0, 32'd0, 32'd0, 32'h0001_0000, 31'h0001_0000);
        rw.p.py = 0;
        rw.p.vy = 0;
        rw.p.ay = 0;
        rw.fixed = '{px: 0, py: 0, vx: 0, vy: 0, ang: 0, life: 32'h0001_0000,
                     live: 1, size: 0, r: 8'hFF, g: 8'hFF, b: 8'hFF, a: 8'hFF};
        directed.push_back(rw);
        // Remaining rows go through the predictor.
        rw.has_fixed = 1'b0;
        // Field extremes and motion wrap.
        rw.p = make_particle(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             31'h7FFF_FFFF);
        directed.push_back(rw);
        rw.p = make_particle(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_8000,
                             31'h0001_0000);
        directed.push_back(rw);
        // Life underflow saturates the remaining life.
        rw.p = make_particle(16'hFFFF, 32'h1234_5678, 32'hFFFF_0000, 32'h8000_0000, 31'd5);
        directed.push_back(rw);
        // Life exactly used up, and one unit left.
        rw.p = make_particle(16'h0100, 32'd1, 32'd3, 32'h0000_0100, 31'd1000);
        directed.push_back(rw);
        rw.p = make_particle(16'h0100, 32'd1, 32'd3, 32'h0000_0101, 31'd1000);
        directed.push_back(rw);
        // Zero full lifetime while alive, and life above the full lifetime.
        rw.p = make_particle(16'h0010, 32'hFFFF_FFFF, 32'd7, 32'h0002_0000, 31'd0);
        directed.push_back(rw);
        rw.p = make_particle(16'h0010, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0009_0000,
                             31'h0001_0000);
        directed.push_back(rw);
        rw.p = make_particle(16'h8000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_C000,
                             31'h0001_0000);
        directed.push_back(rw);

        foreach (directed[i])
        begin
            send_particle(directed[i].p, 1'b0);
            if (directed[i].has_fixed)
                pending_updates[pending_updates.size() - 1] = directed[i].fixed;
        end
        start = 1'b0;
        drain_pipeline();

        // Size and color extremes, including a saturating ramp.
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h00FF_00FF, 32'hFF00_FF00);
        for (int i = 0; i < 6; i++)
            send_particle(make_particle(16'h0100, i * 32'h0000_3000, 32'd9,
                                        32'h0000_0100 + i * 32'h0000_3000, 31'h0001_0000),
                          1'b0);
        start = 1'b0;
        drain_pipeline();

        // Random phases, each with a fresh configuration; one phase never idles.
        for (int phase = 0; phase < 8; phase++)
        begin
            cfg_choice = $urandom_range(3);
            if (cfg_choice == 0)
                configure(32'h0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0);
            else if (cfg_choice == 1)
                configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
            else
                configure(random_word(), random_word(), random_word(), $urandom, $urandom);
            for (int i = 0; i < RANDOM_ITEMS / 8; i++)
                send_particle(random_particle(), phase != 3);
            start = 1'b0;
            // The sender holds off here until every result is back.
            drain_pipeline();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/pus_pkg.sv
src/pus_div.sv
src/particle_update_step.sv
sim/particle_update_step_tb.sv
